### sv/averaged_fan_curve_controller_macros.svh
// ----------------------------------------------------------------------------
// Averaged fan curve controller - assertion macros
// Shared concurrent check helpers for the controller RTL.
// ----------------------------------------------------------------------------
`ifndef AVERAGED_FAN_CURVE_CONTROLLER_MACROS_SVH
`define AVERAGED_FAN_CURVE_CONTROLLER_MACROS_SVH

// condition must hold in the same cycle as the trigger
`define AFCC_ASSERT_NOW(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("afcc: same-cycle check failed");

// condition must hold in the cycle after the trigger
`define AFCC_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("afcc: next-cycle check failed");

`endif

### sv/afcc_pkg.sv
// ----------------------------------------------------------------------------
// afcc_pkg
// Types, codes and curve helpers for the averaged fan curve controller.
// ----------------------------------------------------------------------------
package afcc_pkg;

   typedef struct packed {
      logic [1:0] mode;
      logic [7:0] temperature;
      logic       temp_read_error;
      logic       fan_read_error;
   } req_payload_type;

   typedef struct packed {
      logic       fan_write;
      logic [3:0] fan_level;
      logic       kernel_control;
      logic [7:0] average_temp;
      logic       fault;
   } rsp_payload_type;

   // request modes
   localparam logic [1:0] MODE_TICK    = 2'd0;
   localparam logic [1:0] MODE_ENABLE  = 2'd1;
   localparam logic [1:0] MODE_RELEASE = 2'd2;

   // what a transaction commands on the fan
   localparam logic [1:0] CMD_NONE     = 2'd0;
   localparam logic [1:0] CMD_CURVE    = 2'd1;
   localparam logic [1:0] CMD_FALLBACK = 2'd2;

   // register map
   localparam int         CSR_ADDR_W   = 3;
   localparam logic [0:0] REG_MIN_FAN_LEVEL      = 1'd0;
   localparam logic [0:0] REG_FALLBACK_FAN_LEVEL = 1'd1;
   localparam logic [3:0] MIN_FAN_LEVEL_RESET    = 4'd4;
   localparam logic [3:0] FALLBACK_LEVEL_RESET   = 4'd5;

   localparam logic [3:0] BASE_LEVEL  = 4'd3;
   localparam logic [3:0] TOP_LEVEL   = 4'd11;
   localparam int         CURVE_STEPS = 8;
   localparam logic [7:0] CURVE_EDGE [CURVE_STEPS] =
      '{8'd40, 8'd45, 8'd48, 8'd50, 8'd55, 8'd60, 8'd65, 8'd70};

   function automatic logic [3:0] sat_level(input logic [3:0] value);
      return (value > TOP_LEVEL) ? TOP_LEVEL : value;
   endfunction

   function automatic logic [3:0] curve_level(input logic [7:0] mean);
      logic [3:0] lvl;
      lvl = BASE_LEVEL;
      for (int k = 0; k < CURVE_STEPS; k++) begin
         if (mean >= CURVE_EDGE[k]) begin
            lvl = BASE_LEVEL + 4'd1 + 4'(k);
         end
      end
      return lvl;
   endfunction

endpackage

### sv/averaged_fan_curve_controller.sv
// ----------------------------------------------------------------------------
// averaged_fan_curve_controller
// Moving-average temperature window mapped through a step curve to a fan level.
// ----------------------------------------------------------------------------
// Takes one transaction per clock cycle while the result side is ready and
// returns one result per transaction through the stage 1, stage 2 and result
// registers. The pace is set by the read-modify-write of the sample memory:
// the slot is read at accept (registered read), the running window sum is
// updated and the sample written back as the transaction leaves stage 1, with
// a bypass when a following transaction reads the slot being written. The mean
// (multiply by reciprocal) and the curve lookup take one more stage. Samples
// start as zero through per-entry valid bits, so no clearing pass follows reset.
// ----------------------------------------------------------------------------
`include "averaged_fan_curve_controller_macros.svh"

module averaged_fan_curve_controller
   import afcc_pkg::*;
#(
   parameter int WINDOW = 10
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_payload_type       req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_payload_type       rsp_payload,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   localparam int IDX_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int SUM_W   = $clog2(WINDOW * 255 + 1);
   localparam int LOG_W   = $clog2(WINDOW);
   localparam int SH      = SUM_W + LOG_W;
   localparam int RECIP   = ((2 ** SH) + WINDOW - 1) / WINDOW;
   localparam int RECIP_W = SUM_W + 1;
   localparam int PROD_W  = SUM_W + RECIP_W;

   typedef struct packed {
      logic             store;
      logic [IDX_W-1:0] addr;
      logic [7:0]       temp;
      logic [1:0]       cmd;
      logic             fault;
      logic             kctl;
      logic             fwd;
      logic [7:0]       fwd_data;
   } s1_stage_type;

   typedef struct packed {
      logic [SUM_W-1:0] sum;
      logic [1:0]       cmd;
      logic             fault;
      logic             kctl;
   } s2_stage_type;

   // control state
   logic              kernel_on_ff, kernel_on_in;
   logic [IDX_W-1:0]  ring_index_ff, ring_index_in;
   logic [SUM_W-1:0]  window_sum_ff, window_sum_in;
   logic [WINDOW-1:0] slot_valid_ff, slot_valid_in;
   logic              s1_valid_ff, s1_valid_in;
   logic              s2_valid_ff, s2_valid_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [3:0]        min_level_ff, min_level_in;
   logic [3:0]        fallback_level_ff, fallback_level_in;

   // payload
   s1_stage_type      s1_ff, s1_in;
   s2_stage_type      s2_ff, s2_in;
   rsp_payload_type   rsp_payload_ff, rsp_payload_in;

   logic              accept, out_free, s2_move, s2_free, s1_move, s1_free;
   logic              tick_on, read_err, cfg_write;
   logic [7:0]        ram_rd_data, old_sample;
   logic [SUM_W-1:0]  sum_new;
   logic [PROD_W-1:0] mean_prod;
   logic [7:0]        mean;
   logic [3:0]        curve_lvl, floor_lvl;

   // ---------------------------------------------------------------- handshake
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s2_move   = s2_valid_ff && out_free;
   assign s2_free   = !s2_valid_ff || s2_move;
   assign s1_move   = s1_valid_ff && s2_free;
   assign s1_free   = !s1_valid_ff || s1_move;
   assign req_ready = s1_free;
   assign accept    = req_valid && req_ready;

   assign s1_valid_in  = accept || (s1_valid_ff && !s1_move);
   assign s2_valid_in  = s1_move || (s2_valid_ff && !s2_move);
   assign rsp_valid_in = s2_move || (rsp_valid_ff && !rsp_ready);

   // ---------------------------------------------------------------- accept
   assign tick_on  = (req_payload.mode == MODE_TICK) && kernel_on_ff;
   assign read_err = req_payload.temp_read_error || req_payload.fan_read_error;

   always_comb begin
      kernel_on_in  = kernel_on_ff;
      ring_index_in = ring_index_ff;
      s1_in         = s1_ff;
      if (accept) begin
         s1_in.store    = tick_on && !req_payload.temp_read_error;
         s1_in.addr     = ring_index_ff;
         s1_in.temp     = req_payload.temperature;
         s1_in.fault    = tick_on && read_err;
         // previous transaction writes this slot in the same cycle
         s1_in.fwd      = s1_move && s1_ff.store && (s1_ff.addr == ring_index_ff);
         s1_in.fwd_data = s1_ff.temp;
         s1_in.cmd      = CMD_NONE;
         unique case (req_payload.mode)
            MODE_TICK: begin
               if (kernel_on_ff) begin
                  s1_in.cmd    = read_err ? CMD_FALLBACK : CMD_CURVE;
                  kernel_on_in = !read_err;
               end
            end
            MODE_ENABLE: begin
               kernel_on_in = 1'b1;
            end
            MODE_RELEASE: begin
               if (kernel_on_ff) begin
                  s1_in.cmd = CMD_FALLBACK;
               end
               kernel_on_in = 1'b0;
            end
            default: begin
            end
         endcase
         s1_in.kctl = kernel_on_in;
         if (tick_on) begin
            ring_index_in = (32'(ring_index_ff) == WINDOW - 1) ? '0
                                                               : ring_index_ff + 1'b1;
         end
      end
   end

   afcc_ram #(
      .WIDTH (8),
      .DEPTH (WINDOW)
   ) u_sample_ram (
      .clock   (clock),
      .wr_en   (s1_move && s1_ff.store),
      .wr_addr (s1_ff.addr),
      .wr_data (s1_ff.temp),
      .rd_en   (accept),
      .rd_addr (ring_index_ff),
      .rd_data (ram_rd_data)
   );

   // ---------------------------------------------------------------- stage 1
   always_comb begin
      if (s1_ff.fwd) begin
         old_sample = s1_ff.fwd_data;
      end else if (slot_valid_ff[s1_ff.addr]) begin
         old_sample = ram_rd_data;
      end else begin
         old_sample = '0;
      end
   end

   assign sum_new = window_sum_ff - SUM_W'(old_sample) + SUM_W'(s1_ff.temp);

   always_comb begin
      window_sum_in = window_sum_ff;
      slot_valid_in = slot_valid_ff;
      s2_in         = s2_ff;
      if (s1_move) begin
         if (s1_ff.store) begin
            window_sum_in                = sum_new;
            slot_valid_in[s1_ff.addr]    = 1'b1;
         end
         s2_in.sum   = s1_ff.store ? sum_new : window_sum_ff;
         s2_in.cmd   = s1_ff.cmd;
         s2_in.fault = s1_ff.fault;
         s2_in.kctl  = s1_ff.kctl;
      end
   end

   // ---------------------------------------------------------------- stage 2
   assign mean_prod = PROD_W'(s2_ff.sum) * PROD_W'(RECIP);
   assign mean      = mean_prod[SH +: 8];
   assign curve_lvl = curve_level(mean);
   assign floor_lvl = sat_level(min_level_ff);

   always_comb begin
      rsp_payload_in = rsp_payload_ff;
      if (s2_move) begin
         rsp_payload_in.kernel_control = s2_ff.kctl;
         rsp_payload_in.average_temp   = mean;
         rsp_payload_in.fault          = s2_ff.fault;
         unique case (s2_ff.cmd)
            CMD_CURVE: begin
               rsp_payload_in.fan_write = 1'b1;
               rsp_payload_in.fan_level = (curve_lvl < floor_lvl) ? floor_lvl : curve_lvl;
            end
            CMD_FALLBACK: begin
               rsp_payload_in.fan_write = 1'b1;
               rsp_payload_in.fan_level = sat_level(fallback_level_ff);
            end
            default: begin
               rsp_payload_in.fan_write = 1'b0;
               rsp_payload_in.fan_level = '0;
            end
         endcase
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // ---------------------------------------------------------------- registers
   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite && pready;

   always_comb begin
      min_level_in      = min_level_ff;
      fallback_level_in = fallback_level_ff;
      if (cfg_write) begin
         unique case (paddr[CSR_ADDR_W-1:2])
            REG_MIN_FAN_LEVEL:      min_level_in      = pwdata[3:0];
            REG_FALLBACK_FAN_LEVEL: fallback_level_in = pwdata[3:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (paddr[CSR_ADDR_W-1:2])
         REG_MIN_FAN_LEVEL:      prdata = 32'(min_level_ff);
         REG_FALLBACK_FAN_LEVEL: prdata = 32'(fallback_level_ff);
         default:                prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kernel_on_ff      <= 1'b1;
         ring_index_ff     <= '0;
         window_sum_ff     <= '0;
         slot_valid_ff     <= '0;
         s1_valid_ff       <= 1'b0;
         s2_valid_ff       <= 1'b0;
         rsp_valid_ff      <= 1'b0;
         min_level_ff      <= MIN_FAN_LEVEL_RESET;
         fallback_level_ff <= FALLBACK_LEVEL_RESET;
      end else begin
         kernel_on_ff      <= kernel_on_in;
         ring_index_ff     <= ring_index_in;
         window_sum_ff     <= window_sum_in;
         slot_valid_ff     <= slot_valid_in;
         s1_valid_ff       <= s1_valid_in;
         s2_valid_ff       <= s2_valid_in;
         rsp_valid_ff      <= rsp_valid_in;
         min_level_ff      <= min_level_in;
         fallback_level_ff <= fallback_level_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff          <= s1_in;
      s2_ff          <= s2_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   // ---------------------------------------------------------------- checks
   `AFCC_ASSERT_NOW(a_fault_hands_back, clock, reset,
      rsp_valid_ff && rsp_payload_ff.fault,
      !rsp_payload_ff.kernel_control && rsp_payload_ff.fan_write)
   `AFCC_ASSERT_NOW(a_stall_only_when_full, clock, reset, !req_ready,
      s1_valid_ff && s2_valid_ff && rsp_valid_ff && !rsp_ready)
   `AFCC_ASSERT_NOW(a_index_in_window, clock, reset, 1'b1, 32'(ring_index_ff) < WINDOW)
   `AFCC_ASSERT_NOW(a_sum_bounded, clock, reset, 1'b1, 32'(window_sum_ff) <= WINDOW * 255)
   `AFCC_ASSERT_NEXT(a_enable_sets_control, clock, reset,
      accept && req_payload.mode == MODE_ENABLE, kernel_on_ff)

endmodule

### sv/afcc_ram.sv
// ----------------------------------------------------------------------------
// afcc_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module afcc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 10
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read returns the old contents when both ports hit one entry
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
